### src/erf_pkg.sv
package erf_pkg;

  localparam int UW = 32;
  localparam int HW = 36;
  localparam int RW = 32;
  localparam int NSTEP = 6;

  localparam logic [HW-1:0] COEF_A6 = 36'd46239;

  localparam logic [HW-1:0] HORNER_COEF [NSTEP] = '{
    36'd296962,
    36'd163224,
    36'd9954153,
    36'd45399965,
    36'd75723579,
    36'd1073741824
  };

  typedef struct packed {
    logic v;
    logic neg;
  } ctl_t;

endpackage

### src/erf_horner.sv
module erf_horner (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  erf_pkg::ctl_t            ctl_i,
  input  logic [erf_pkg::UW-1:0]   u_i,
  output erf_pkg::ctl_t            ctl_o,
  output logic [erf_pkg::HW-1:0]   t_o
);

  localparam int N = erf_pkg::NSTEP;
  localparam int PW = erf_pkg::UW + erf_pkg::HW;

  erf_pkg::ctl_t             ctl_q [N];
  logic [erf_pkg::UW-1:0]    u_q   [N];
  logic [erf_pkg::HW-1:0]    h_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    erf_pkg::ctl_t          c_in;
    logic [erf_pkg::UW-1:0] u_in;
    logic [erf_pkg::HW-1:0] h_in;
    logic [PW-1:0]          prod;
    logic [PW-1:0]          rnd;
    logic [erf_pkg::HW-1:0] h_d;

    if (k == 0) begin : g_first
      assign c_in = ctl_i;
      assign u_in = u_i;
      assign h_in = erf_pkg::COEF_A6;
    end else begin : g_next
      assign c_in = ctl_q[k-1];
      assign u_in = u_q[k-1];
      assign h_in = h_q[k-1];
    end

    always_comb begin
      prod = PW'(u_in) * PW'(h_in);
      rnd  = (prod + (PW'(1) << 27)) >> 28;
      h_d  = erf_pkg::HORNER_COEF[k] + rnd[erf_pkg::HW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        u_q[k] <= u_in;
        h_q[k] <= h_d;
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign t_o   = h_q[N-1];

endmodule

### src/erf_div.sv
module erf_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  erf_pkg::ctl_t            ctl_i,
  input  logic [erf_pkg::HW-1:0]   t_i,
  output erf_pkg::ctl_t            ctl_o,
  output logic [erf_pkg::RW-1:0]   r_o
);

  localparam int N  = erf_pkg::RW;
  localparam int HW = erf_pkg::HW;

  erf_pkg::ctl_t  ctl_q [N];
  logic [HW-1:0]  rem_q [N];
  logic [HW-1:0]  t_q   [N];
  logic [N-1:0]   num_q [N];
  logic [N-1:0]   q_q   [N];

  logic [HW-1:0]  half_t;
  assign half_t = t_i >> 1;

  for (genvar j = 0; j < N; j++) begin : g_bit
    erf_pkg::ctl_t c_in;
    logic [HW-1:0] rem_in;
    logic [HW-1:0] t_in;
    logic [N-1:0]  num_in;
    logic [N-1:0]  q_in;
    logic [HW:0]   sh;
    logic          ge;
    logic [HW:0]   dif;
    logic [HW-1:0] rem_d;

    if (j == 0) begin : g_first
      assign c_in   = ctl_i;
      assign t_in   = t_i;
      assign rem_in = (HW'(1) << 29) + (half_t >> N);
      assign num_in = half_t[N-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign c_in   = ctl_q[j-1];
      assign t_in   = t_q[j-1];
      assign rem_in = rem_q[j-1];
      assign num_in = num_q[j-1];
      assign q_in   = q_q[j-1];
    end

    always_comb begin
      sh    = {rem_in, num_in[N-1]};
      ge    = sh >= {1'b0, t_in};
      dif   = sh - {1'b0, t_in};
      rem_d = ge ? dif[HW-1:0] : sh[HW-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[j] <= '0;
      end else if (en_i) begin
        ctl_q[j] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q[j]   <= t_in;
        rem_q[j] <= rem_d;
        num_q[j] <= num_in << 1;
        q_q[j]   <= {q_in[N-2:0], ge};
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign r_o   = q_q[N-1];

endmodule

### src/erf_sq.sv
module erf_sq #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  erf_pkg::ctl_t            ctl_i,
  input  logic [erf_pkg::RW-1:0]   r_i,
  output logic                     valid_o,
  output logic [OUT_WIDTH-1:0]     value_o
);

  localparam int N  = 4;
  localparam int RW = erf_pkg::RW;
  localparam int SH = 32 - OUT_WIDTH;

  erf_pkg::ctl_t   ctl_q [N];
  logic [RW-1:0]   r_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_sq
    erf_pkg::ctl_t c_in;
    logic [RW-1:0] r_in;
    logic [2*RW-1:0] prod;
    logic [2*RW-1:0] rnd;

    if (k == 0) begin : g_first
      assign c_in = ctl_i;
      assign r_in = r_i;
    end else begin : g_next
      assign c_in = ctl_q[k-1];
      assign r_in = r_q[k-1];
    end

    always_comb begin
      prod = (2*RW)'(r_in) * (2*RW)'(r_in);
      rnd  = (prod + ((2*RW)'(1) << 30)) >> 31;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= c_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= rnd[RW-1:0];
      end
    end
  end

  logic [32:0]          e;
  logic [32:0]          es;
  logic [32:0]          emax;
  logic [OUT_WIDTH-1:0] mag;
  logic [OUT_WIDTH-1:0] value_d;
  logic                 valid_q;
  logic [OUT_WIDTH-1:0] value_q;

  assign e    = (33'(1) << 31) - 33'(r_q[N-1]);
  assign emax = (33'(1) << (OUT_WIDTH - 1)) - 33'(1);

  if (SH > 0) begin : g_round
    assign es = (e + (33'(1) << (SH - 1))) >> SH;
  end else begin : g_noround
    assign es = e;
  end

  always_comb begin
    mag     = (es > emax) ? emax[OUT_WIDTH-1:0] : es[OUT_WIDTH-1:0];
    value_d = ctl_q[N-1].neg ? (~mag + OUT_WIDTH'(1)) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_q[N-1].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
    end
  end

  assign valid_o = valid_q;
  assign value_o = value_q;

endmodule

### src/erf_polynomial_approx.sv
// pipeline: 1 abs, 6 horner, 32 divide, 4 square, 1 out stage registers from input accept to result valid
// throughput: one word per cycle while the output word is not held; the whole pipeline advances together on one enable
// stall: when the output word is held, every stage holds and input ready drops
// reset: rst_ni async active low clears all stage valid bits; data registers are not reset
module erf_polynomial_approx #(
  parameter int IN_WIDTH  = 16,
  parameter int OUT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_WIDTH-1:0]  x_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_WIDTH-1:0] erf_value_o
);

  localparam int UW = erf_pkg::UW;

  logic                    en;
  erf_pkg::ctl_t           ctl_d;
  erf_pkg::ctl_t           ctl_q;
  logic [IN_WIDTH-1:0]     mag;
  logic [UW-1:0]           u_d;
  logic [UW-1:0]           u_q;
  erf_pkg::ctl_t           hctl;
  logic [erf_pkg::HW-1:0]  t;
  erf_pkg::ctl_t           dctl;
  logic [erf_pkg::RW-1:0]  r;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    ctl_d.v   = in_valid_i;
    ctl_d.neg = x_sample_i[IN_WIDTH-1];
    mag       = ctl_d.neg ? (~x_sample_i + IN_WIDTH'(1)) : x_sample_i;
    u_d       = UW'(mag) << (UW - IN_WIDTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= u_d;
    end
  end

  erf_horner u_horner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (ctl_q),
    .u_i    (u_q),
    .ctl_o  (hctl),
    .t_o    (t)
  );

  erf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (hctl),
    .t_i    (t),
    .ctl_o  (dctl),
    .r_o    (r)
  );

  erf_sq #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_sq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (dctl),
    .r_i     (r),
    .valid_o (out_valid_o),
    .value_o (erf_value_o)
  );

endmodule
